// File: sv/assert_macros.svh
// Assertion macros for the RTL, included by mcpi_merge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define MCPI_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent, outside reset.
`define MCPI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/mcpi_pkg.sv
// Shared constants, types and functions of the Monte Carlo pi tosser.
package mcpi_pkg;

    localparam int LANES       = 8;
    localparam int TOTAL_WIDTH = 40;
    localparam int HIT_W       = $clog2(LANES + 1);

    localparam int SEED_WORDS  = 8;
    localparam int SEED_REGS   = 4;
    localparam int REG_IDX_W   = 2;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 64;

    localparam logic [DATA_W-1:0] SEED_RESET = 64'd1;

    localparam int OUT_TOTAL_W = 40;
    localparam logic [63:0] OUT_TOTAL_MAX = 64'h0000_00FF_FFFF_FFFF;
    localparam int BATCH_W = 4;
    localparam logic [BATCH_W-1:0] BATCH_MAX = 4'hF;

    // (2^32-1)^2
    localparam logic [64:0] FULL_SQ = 65'h0_FFFF_FFFE_0000_0001;

    typedef logic [31:0] t_word;
    typedef t_word t_seed_words [SEED_WORDS];

    typedef struct packed {
        logic accept;  // input transaction taken, generators step
        logic adv1;    // draw stage loads
        logic adv2;    // square stage loads
        logic adv3;    // compare stage loads
    } t_pipe_ctl;

    function automatic t_word xorshift32(input t_word s);
        t_word v;
        v = s ^ (s << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // Word of a seed register that a lane takes after reset.
    function automatic t_word seed_reset_word(input int lane);
        int w;
        w = lane % SEED_WORDS;
        return (w % 2 == 1) ? SEED_RESET[63:32] : SEED_RESET[31:0];
    endfunction

    function automatic logic [HIT_W-1:0] count_hits(input logic [LANES-1:0] v);
        logic [HIT_W-1:0] c;
        c = '0;
        for (int i = 0; i < LANES; i++) begin
            c = c + HIT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

// File: sv/mcpi_seed_regs.sv
// APB register file holding the four 64-bit seed registers.
module mcpi_seed_regs
    import mcpi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_seed_words       o_seeds
);

    logic [DATA_W-1:0]    r_seed [SEED_REGS];
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = r_seed[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEED_REGS; i++) begin
                r_seed[i] <= SEED_RESET;
            end
        end else if (wr_en) begin
            r_seed[idx] <= pwdata;
        end
    end

    always_comb begin
        for (int i = 0; i < SEED_REGS; i++) begin
            o_seeds[2*i]     = r_seed[i][31:0];
            o_seeds[2*i + 1] = r_seed[i][63:32];
        end
    end

endmodule

// File: sv/mcpi_lane.sv
// One tossing lane: xorshift32 generator, squaring and circle test.
module mcpi_lane
    import mcpi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  logic      i_restart,
    input  logic      i_count,
    input  t_word     i_seed,
    input  t_word     i_seed_init,
    output logic      o_hit
);

    t_word       r_gen;
    t_word       base;
    t_word       n_sx;
    t_word       n_sy;
    t_word       r_sx;
    t_word       r_sy;
    logic        r_cnt1;
    logic [63:0] r_sqx;
    logic [63:0] r_sqy;
    logic        r_cnt2;
    logic [64:0] sum;
    logic        r_hit;

    assign base = i_restart ? i_seed : r_gen;
    assign n_sx = xorshift32(base);
    assign n_sy = xorshift32(n_sx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= i_seed_init;
        end else if (i_ctl.accept) begin
            r_gen <= n_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv1) begin
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_cnt1 <= i_count;
        end
        if (i_ctl.adv2) begin
            r_sqx  <= 64'(r_sx) * 64'(r_sx);
            r_sqy  <= 64'(r_sy) * 64'(r_sy);
            r_cnt2 <= r_cnt1;
        end
        if (i_ctl.adv3) begin
            r_hit <= r_cnt2 && (sum <= FULL_SQ);
        end
    end

    assign sum   = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign o_hit = r_hit;

endmodule

// File: sv/mcpi_merge.sv
// Merges lane hits into the batch count and the saturating running total.
module mcpi_merge
    import mcpi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_restart,
    input  logic [LANES-1:0]       i_hits,
    input  logic                   i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [BATCH_W-1:0]     o_batch_hits,
    output logic [OUT_TOTAL_W-1:0] o_total_hits
);

`include "assert_macros.svh"

    logic [HIT_W-1:0]       hits;
    logic [TOTAL_WIDTH-1:0] tot_base;
    logic [TOTAL_WIDTH:0]   tot_sum;
    logic [TOTAL_WIDTH-1:0] n_total;
    logic [TOTAL_WIDTH-1:0] r_total;
    logic [63:0]            tot_ext;
    logic                   r_out_v;
    logic [BATCH_W-1:0]     r_batch;
    logic [OUT_TOTAL_W-1:0] r_shown;

    assign hits     = count_hits(i_hits);
    assign tot_base = i_restart ? '0 : r_total;
    assign tot_sum  = {1'b0, tot_base} + (TOTAL_WIDTH + 1)'(hits);
    assign n_total  = tot_sum[TOTAL_WIDTH] ? '1 : tot_sum[TOTAL_WIDTH-1:0];
    assign tot_ext  = 64'(n_total);

    assign o_ready = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_total <= '0;
        end else begin
            if (o_ready) begin
                r_out_v <= i_load;
            end
            if (i_load && o_ready) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_batch <= (32'(hits) > 32'(BATCH_MAX)) ? BATCH_MAX : BATCH_W'(hits);
            r_shown <= (tot_ext > OUT_TOTAL_MAX) ? OUT_TOTAL_MAX[OUT_TOTAL_W-1:0]
                                                 : tot_ext[OUT_TOTAL_W-1:0];
        end
    end

    assign o_valid      = r_out_v;
    assign o_batch_hits = r_batch;
    assign o_total_hits = r_shown;

    `MCPI_ASSERT_NEXT(a_total_grows, i_load && o_ready && !i_restart, r_total >= $past(r_total))
    `MCPI_ASSERT_NEXT(a_restart_total, i_load && o_ready && i_restart,
                      r_total == TOTAL_WIDTH'($past(hits)))
    `MCPI_ASSERT_NEXT(a_total_hold, !(i_load && o_ready), $stable(r_total))

endmodule

// File: sv/monte_carlo_pi_tosser.sv
// Pipeline: four registered stages (draw, square, compare, merge) from an accepted
// batch to o_valid. Throughput: one batch per cycle unless stalled; the generator
// feedback (two xorshift32 steps per lane, combinational) sets that rate, squaring and
// compare are pipelined after it. Reset (synchronous, active low): seeds return to 1,
// lanes load them, total clears, pipeline empties. No clearing pass.
module monte_carlo_pi_tosser
    import mcpi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [3:0]             i_valid_lanes,
    input  logic                   i_restart,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [BATCH_W-1:0]     o_batch_hits,
    output logic [OUT_TOTAL_W-1:0] o_total_hits,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    t_seed_words      seeds;
    t_pipe_ctl        ctl;
    logic [LANES-1:0] lane_hit;
    logic             out_ready;
    logic             r_v1, r_v2, r_v3;
    logic             r_rst1, r_rst2, r_rst3;

    mcpi_seed_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_seeds (seeds)
    );

    // each stage moves when empty or when the one after it moves
    assign ctl.adv3   = !r_v3 || out_ready;
    assign ctl.adv2   = !r_v2 || ctl.adv3;
    assign ctl.adv1   = !r_v1 || ctl.adv2;
    assign ctl.accept = i_valid && ctl.adv1;
    assign o_stall    = !ctl.adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ctl.adv1) r_v1 <= i_valid;
            if (ctl.adv2) r_v2 <= r_v1;
            if (ctl.adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv1) r_rst1 <= i_restart;
        if (ctl.adv2) r_rst2 <= r_rst1;
        if (ctl.adv3) r_rst3 <= r_rst2;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mcpi_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_restart   (i_restart),
            .i_count     (32'(g) < 32'(i_valid_lanes)),
            .i_seed      (seeds[g % SEED_WORDS]),
            .i_seed_init (seed_reset_word(g)),
            .o_hit       (lane_hit[g])
        );
    end

    mcpi_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_v3),
        .i_restart    (r_rst3),
        .i_hits       (lane_hit),
        .i_stall      (i_stall),
        .o_ready      (out_ready),
        .o_valid      (o_valid),
        .o_batch_hits (o_batch_hits),
        .o_total_hits (o_total_hits)
    );

endmodule

// File: tb/mcpi_toss_checker.sv
// Checker for the pi tosser: tracks the seed registers, predicts each batch, compares results.
module mcpi_toss_checker
    import mcpi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [3:0]             i_valid_lanes,
    input  logic                   i_restart,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [BATCH_W-1:0]     i_batch_hits,
    input  logic [OUT_TOTAL_W-1:0] i_total_hits,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic                   i_pready,
    input  logic [ADDR_W-1:0]      i_paddr,
    input  logic [DATA_W-1:0]      i_pwdata,
    output int                     o_mismatches,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BATCH_W-1:0]     hits;
        logic [OUT_TOTAL_W-1:0] total;
    } t_toss_result;

    localparam logic [63:0] SEED_AT_RESET = 64'd1;
    // (2^32-1)^2, radius squared at full scale
    localparam logic [64:0] UNIT_SQ       = 65'h0_FFFF_FFFE_0000_0001;
    localparam logic [63:0] TOTAL_CAP     = {64{1'b1}} >> (64 - TOTAL_WIDTH);
    localparam logic [63:0] SHOWN_CAP     = (64'd1 << OUT_TOTAL_W) - 64'd1;

    logic [63:0]  seed_bank [SEED_REGS];
    logic [31:0]  lane_state [LANES];
    logic [63:0]  hit_sum;
    t_toss_result result_q [$];
    int           mismatches = 0;
    int           pending_cnt = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending_cnt;

    function automatic logic [31:0] xs_step(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ {s[18:0], 13'd0};
        t = t ^ {17'd0, t[31:17]};
        t = t ^ {t[26:0], 5'd0};
        return t;
    endfunction

    function automatic logic [31:0] lane_seed(input int lane);
        int w;
        w = lane % 8;
        return (w % 2 == 1) ? seed_bank[w / 2][63:32] : seed_bank[w / 2][31:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic reload_lanes();
        int i;
        for (i = 0; i < LANES; i++) begin
            lane_state[i] = lane_seed(i);
        end
    endtask

    task automatic reset_model();
        int i;
        for (i = 0; i < SEED_REGS; i++) begin
            seed_bank[i] = SEED_AT_RESET;
        end
        reload_lanes();
        hit_sum = '0;
        result_q.delete();
    endtask

    // One batch: every lane draws x then y, only the leading lanes are scored.
    task automatic toss_batch(input logic [3:0] vl, input logic rs, output t_toss_result res);
        int          i;
        int          counted;
        int          hits;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [64:0] mag;
        if (rs) begin
            reload_lanes();
            hit_sum = '0;
        end
        counted = (int'(vl) > LANES) ? LANES : int'(vl);
        hits = 0;
        for (i = 0; i < LANES; i++) begin
            sx = xs_step(lane_state[i]);
            sy = xs_step(sx);
            lane_state[i] = sy;
            mag = {1'b0, 64'(sx) * 64'(sx)} + {1'b0, 64'(sy) * 64'(sy)};
            if (i < counted && mag <= UNIT_SQ) begin
                hits++;
            end
        end
        if (hit_sum > TOTAL_CAP - 64'(hits)) begin
            hit_sum = TOTAL_CAP;
        end else begin
            hit_sum = hit_sum + 64'(hits);
        end
        res.hits  = (hits > 15) ? '1 : BATCH_W'(hits);
        res.total = (hit_sum > SHOWN_CAP) ? SHOWN_CAP[OUT_TOTAL_W-1:0]
                                          : hit_sum[OUT_TOTAL_W-1:0];
    endtask

    always @(posedge i_clk) begin : watch
        t_toss_result want;
        int           idx;
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report_mismatch($sformatf("result hits=%0d total=%0d with no batch pending",
                                              i_batch_hits, i_total_hits));
                end else begin
                    want = result_q.pop_front();
                    if (i_batch_hits !== want.hits) begin
                        report_mismatch($sformatf("batch_hits got %0d want %0d",
                                                  i_batch_hits, want.hits));
                    end
                    if (i_total_hits !== want.total) begin
                        report_mismatch($sformatf("total_hits got %0d want %0d",
                                                  i_total_hits, want.total));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                toss_batch(i_valid_lanes, i_restart, want);
                result_q.push_back(want);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = int'(i_paddr) / 8;
                if (idx < SEED_REGS) begin
                    seed_bank[idx] = i_pwdata;
                end
            end
        end
        pending_cnt <= result_q.size();
    end

endmodule

// File: tb/tb_monte_carlo_pi_tosser.sv
// Testbench top: drives batches, output stalls and seed writes, and gives the verdict.
module tb_monte_carlo_pi_tosser;
    timeunit 1ns;
    timeprecision 1ps;

    import mcpi_pkg::*;

    typedef enum {SEEDS_ZERO, SEEDS_ONES, SEEDS_MIXED, SEEDS_RANDOM} t_seed_style;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic [3:0]             i_valid_lanes = '0;
    logic                   i_restart = 1'b0;
    logic                   i_stall = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic [BATCH_W-1:0]     o_batch_hits;
    logic [OUT_TOTAL_W-1:0] o_total_hits;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    int          mismatches;
    int          pending;
    int          cycles = 0;
    bit          calm = 1'b0;
    logic [63:0] seed_plan [SEED_REGS];

    always #2 i_clk = ~i_clk;

    monte_carlo_pi_tosser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_valid_lanes (i_valid_lanes),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_batch_hits  (o_batch_hits),
        .o_total_hits  (o_total_hits),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mcpi_toss_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_valid_lanes (i_valid_lanes),
        .i_restart     (i_restart),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_batch_hits  (o_batch_hits),
        .i_total_hits  (o_total_hits),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("monte_carlo_pi_tosser verification failed");
            $finish;
        end
    end

    // Receiver side: random stall before each result transaction.
    initial begin : result_stall
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_batch(input logic [3:0] vl, input logic rs);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_valid_lanes <= vl;
        i_restart     <= rs;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Back-to-back APB writes; psel drops only after the last access.
    task automatic write_seed_bank();
        int i;
        for (i = 0; i < SEED_REGS; i++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(i * 8);
            pwdata  <= seed_plan[i];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input t_seed_style style, input bit quiet);
        int         i;
        logic [3:0] vl;
        wait_drained();
        calm = quiet;
        for (i = 0; i < SEED_REGS; i++) begin
            case (style)
                SEEDS_ZERO:  seed_plan[i] = 64'd0;
                SEEDS_ONES:  seed_plan[i] = {64{1'b1}};
                SEEDS_MIXED: seed_plan[i] = (i % 2 == 0) ? {$urandom, 32'd0}
                                                         : {32'hFFFF_FFFF, $urandom};
                default:     seed_plan[i] = {$urandom, $urandom};
            endcase
        end
        write_seed_bank();
        // lanes keep their old state until a restart
        for (i = 0; i < 3; i++) begin
            send_batch(4'($urandom_range(0, 15)), 1'b0);
        end
        send_batch(4'($urandom_range(1, LANES)), 1'b1);
        for (i = 0; i < PHASE_ITEMS; i++) begin
            vl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, LANES));
            send_batch(vl, 1'($urandom_range(0, 24) == 0));
        end
    endtask

    initial begin : stimulus
        int v;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset seeds: sweep every lane count, including zero and above LANES
        for (v = 0; v < 16; v++) begin
            send_batch(4'(v), v == 5 || v == 12);
        end
        run_phase(SEEDS_ZERO, 1'b0);
        run_phase(SEEDS_ONES, 1'b1);
        run_phase(SEEDS_MIXED, 1'b0);
        run_phase(SEEDS_RANDOM, 1'b0);
        run_phase(SEEDS_RANDOM, 1'b1);
        run_phase(SEEDS_RANDOM, 1'b0);
        wait_drained();
        if (mismatches == 0) begin
            $display("monte_carlo_pi_tosser verification clean");
        end else begin
            $display("monte_carlo_pi_tosser verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/mcpi_pkg.sv
sv/mcpi_seed_regs.sv
sv/mcpi_lane.sv
sv/mcpi_merge.sv
sv/monte_carlo_pi_tosser.sv
tb/mcpi_toss_checker.sv
tb/tb_monte_carlo_pi_tosser.sv
